FILE: src/rcam_pkg.sv
// Shared constants for the region-of-interest chroma activity meter.
package rcam_pkg;

  localparam int MAX_CHROMA_SIZE = 2048;
  localparam int FRACTION_BITS   = 16;

  localparam int POS_W   = $clog2(MAX_CHROMA_SIZE);
  localparam int DIM_W   = POS_W + 1;
  localparam int COUNT_W = 23;
  localparam int AREA_W  = 2 * POS_W + 1;
  localparam int FRAC_W  = FRACTION_BITS + 1;
  localparam int SUB_W   = (COUNT_W > AREA_W + 1) ? COUNT_W + 1 : AREA_W + 1;
  localparam int STEP_W  = $clog2(FRACTION_BITS);

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [7:0] NEUTRAL   = 8'd128;
  localparam logic [7:0] DEAD_BAND = 8'd16;

  localparam logic [2:0] REG_CHROMA_WIDTH = 3'd0;
  localparam logic [2:0] REG_ROI_LEFT     = 3'd1;
  localparam logic [2:0] REG_ROI_TOP      = 3'd2;
  localparam logic [2:0] REG_ROI_WIDTH    = 3'd3;
  localparam logic [2:0] REG_ROI_HEIGHT   = 3'd4;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_AREA  = 3'd1;
  localparam logic [2:0] ST_CHECK = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  typedef logic [2:0] state_t;

  function automatic logic off_neutral(input logic [7:0] s);
    logic [7:0] d;
    d = (s >= NEUTRAL) ? (s - NEUTRAL) : (NEUTRAL - s);
    return d > DEAD_BAND;
  endfunction

endpackage

FILE: src/roi_chroma_activity_meter_unit.sv
// Top level: chroma activity counter with a shared serial divider for the fractions.
//
// Input stream: one beat per chroma sample in raster order, tdata = {v, u},
// tlast marks the last sample of a frame. Column and row are tracked here.
// Inside the region the block counts V and U samples more than 16 off 128.
// Ordinary beats are accepted back to back, one per cycle, while idle.
// A tlast beat launches the fraction computation: an area product step,
// then for each of the two counts a compare step and, unless the area is
// 0 or the count reaches it (result 0 or saturated), a restoring division
// of the 16 fraction bits on the one shared subtractor, then a step to load
// the output register. During all of this in_tready is low.
// The result beat (motion and presence fractions, Q1.16) sits in an output
// register; samples keep flowing while it waits. If the receiver still
// stalls when the next frame's result is ready, the block holds it and
// stays not ready until out_tready frees the register.
// Reset (rst_n low, synchronous) restores the register defaults, clears
// position and counts, and drops out_tvalid.
// Registers on the APB port at byte addresses 0,4,8,12,16: chroma_width,
// roi_left, roi_top, roi_width, roi_height; write only while idle.
module roi_chroma_activity_meter_unit
  import rcam_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // u_sample [7:0], v_sample [15:8]
  input  logic        in_tlast,   // frame_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // motion_fraction [16:0], presence_fraction [33:17], zeros
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [DIM_W-1:0]   chroma_width_r;
  logic [POS_W-1:0]   roi_left_r;
  logic [POS_W-1:0]   roi_top_r;
  logic [DIM_W-1:0]   roi_width_r;
  logic [DIM_W-1:0]   roi_height_r;

  logic [POS_W-1:0]   col_r;
  logic [POS_W-1:0]   row_r;
  logic [COUNT_W-1:0] mot_cnt_r;
  logic [COUNT_W-1:0] pres_cnt_r;

  state_t             state_r;
  state_t             state_nxt;
  logic               sel_r;
  logic [COUNT_W-1:0] mot_cap_r;
  logic [COUNT_W-1:0] pres_cap_r;
  logic [AREA_W-1:0]  area_r;
  logic [SUB_W-2:0]   rem_r;
  logic [FRAC_W-1:0]  quo_r;
  logic [FRAC_W-1:0]  mot_frac_r;
  logic [STEP_W-1:0]  step_r;
  logic               out_valid_r;
  logic [FRAC_W-1:0]  out_mot_r;
  logic [FRAC_W-1:0]  out_pres_r;

  logic               cfg_wr;
  logic               in_acc;
  logic [7:0]         u_s;
  logic [7:0]         v_s;
  logic [DIM_W-1:0]   eff_width;
  logic [DIM_W:0]     col_end;
  logic [DIM_W:0]     row_end;
  logic               roi_hit;
  logic [COUNT_W-1:0] mot_nxt;
  logic [COUNT_W-1:0] pres_nxt;
  logic               wrap;
  logic [COUNT_W-1:0] cur_cap;
  logic [SUB_W-1:0]   sub_a;
  logic [SUB_W:0]     diff;
  logic               ge;
  logic               out_free;
  logic [2*DIM_W-1:0] prod;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_comb begin
    cfg_prdata = '0;
    case (cfg_paddr[4:2])
      REG_CHROMA_WIDTH: cfg_prdata = {{(32-DIM_W){1'b0}}, chroma_width_r};
      REG_ROI_LEFT:     cfg_prdata = {{(32-POS_W){1'b0}}, roi_left_r};
      REG_ROI_TOP:      cfg_prdata = {{(32-POS_W){1'b0}}, roi_top_r};
      REG_ROI_WIDTH:    cfg_prdata = {{(32-DIM_W){1'b0}}, roi_width_r};
      REG_ROI_HEIGHT:   cfg_prdata = {{(32-DIM_W){1'b0}}, roi_height_r};
      default:          cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chroma_width_r <= DIM_W'(320);
      roi_left_r     <= POS_W'(80);
      roi_top_r      <= POS_W'(60);
      roi_width_r    <= DIM_W'(160);
      roi_height_r   <= DIM_W'(120);
    end else if (cfg_wr) begin
      case (cfg_paddr[4:2])
        REG_CHROMA_WIDTH: chroma_width_r <= cfg_pwdata[DIM_W-1:0];
        REG_ROI_LEFT:     roi_left_r     <= cfg_pwdata[POS_W-1:0];
        REG_ROI_TOP:      roi_top_r      <= cfg_pwdata[POS_W-1:0];
        REG_ROI_WIDTH:    roi_width_r    <= cfg_pwdata[DIM_W-1:0];
        REG_ROI_HEIGHT:   roi_height_r   <= cfg_pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Sample path
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid & in_tready;
  assign u_s       = in_tdata[7:0];
  assign v_s       = in_tdata[15:8];

  assign eff_width = (chroma_width_r == '0 || chroma_width_r > DIM_W'(MAX_CHROMA_SIZE))
                     ? DIM_W'(MAX_CHROMA_SIZE) : chroma_width_r;
  assign col_end   = {2'b0, roi_left_r} + {1'b0, roi_width_r};
  assign row_end   = {2'b0, roi_top_r} + {1'b0, roi_height_r};
  assign roi_hit   = (col_r >= roi_left_r) && ({2'b0, col_r} < col_end) &&
                     (row_r >= roi_top_r) && ({2'b0, row_r} < row_end);
  assign mot_nxt   = (roi_hit && off_neutral(v_s) && mot_cnt_r != COUNT_MAX)
                     ? mot_cnt_r + 1'b1 : mot_cnt_r;
  assign pres_nxt  = (roi_hit && off_neutral(u_s) && pres_cnt_r != COUNT_MAX)
                     ? pres_cnt_r + 1'b1 : pres_cnt_r;
  assign wrap      = ({1'b0, col_r} + 1'b1) >= {1'b0, eff_width};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      mot_cnt_r  <= '0;
      pres_cnt_r <= '0;
    end else if (in_acc) begin
      if (in_tlast) begin
        col_r      <= '0;
        row_r      <= '0;
        mot_cnt_r  <= '0;
        pres_cnt_r <= '0;
      end else begin
        mot_cnt_r  <= mot_nxt;
        pres_cnt_r <= pres_nxt;
        if (wrap) begin
          col_r <= '0;
          row_r <= row_r + 1'b1;
        end else begin
          col_r <= col_r + 1'b1;
        end
      end
    end
  end

  // Shared subtractor: count vs area check, then one restoring-division step a cycle
  assign cur_cap  = sel_r ? pres_cap_r : mot_cap_r;
  assign sub_a    = (state_r == ST_DIV) ? {rem_r, 1'b0} : SUB_W'(cur_cap);
  assign diff     = {1'b0, sub_a} - (SUB_W + 1)'(area_r);
  assign ge       = ~diff[SUB_W];
  assign out_free = ~out_valid_r | out_tready;
  assign prod     = roi_width_r * roi_height_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_acc && in_tlast) state_nxt = ST_AREA;
      ST_AREA:  state_nxt = ST_CHECK;
      ST_CHECK: begin
        if (area_r == '0 || ge) state_nxt = sel_r ? ST_OUT : ST_CHECK;
        else                    state_nxt = ST_DIV;
      end
      ST_DIV:   if (step_r == '0) state_nxt = sel_r ? ST_OUT : ST_CHECK;
      ST_OUT:   if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      sel_r   <= 1'b0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        ST_IDLE:  sel_r <= 1'b0;
        ST_CHECK: begin
          step_r <= STEP_W'(FRACTION_BITS - 1);
          if (area_r == '0 || ge) sel_r <= 1'b1;
        end
        ST_DIV: begin
          step_r <= step_r - 1'b1;
          if (step_r == '0) sel_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_acc && in_tlast) begin
          mot_cap_r  <= mot_nxt;
          pres_cap_r <= pres_nxt;
        end
      end
      ST_AREA:  area_r <= prod[AREA_W-1:0];
      ST_CHECK: begin
        rem_r <= cur_cap[SUB_W-2:0];
        quo_r <= '0;
        if (!sel_r) begin
          if (area_r == '0)    mot_frac_r <= '0;
          else if (ge)         mot_frac_r <= FRAC_W'(1) << FRACTION_BITS;
        end
        if (sel_r) begin
          if (area_r == '0)    quo_r <= '0;
          else if (ge)         quo_r <= FRAC_W'(1) << FRACTION_BITS;
        end
      end
      ST_DIV: begin
        rem_r <= ge ? diff[SUB_W-2:0] : sub_a[SUB_W-2:0];
        quo_r <= {quo_r[FRAC_W-2:0], ge};
        if (step_r == '0 && !sel_r) mot_frac_r <= {quo_r[FRAC_W-2:0], ge};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_OUT && out_free) begin
      out_mot_r  <= mot_frac_r;
      out_pres_r <= quo_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(40-2*FRAC_W){1'b0}}, out_pres_r, out_mot_r};

endmodule
